@@ rtl/core/rmse_pkg.sv @@
`timescale 1ns / 1ps

package rmse_pkg;

    localparam int SUM_W       = 44;
    localparam int RMS_W       = 24;
    localparam int COUNT_OUT_W = 13;
    localparam int MAG_W       = 17;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int DIVIDEND_W  = SUM_W + 16;
    localparam int ROOT_W      = DIVIDEND_W / 2;
    localparam int ALU_W       = ROOT_W + 4;
    localparam int STEP_W      = 6;

    localparam logic [STEP_W-1:0] DIV_LAST_STEP  = STEP_W'(DIVIDEND_W - 1);
    localparam logic [STEP_W-1:0] ROOT_LAST_STEP = STEP_W'(ROOT_W - 1);

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [RMS_W-1:0] RMS_MAX = {RMS_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIVIDE,
        ST_ROOT,
        ST_FINISH
    } rmse_state_t;

endpackage

@@ rtl/core/rmse_alu.sv @@
`timescale 1ns / 1ps

module rmse_alu
    import rmse_pkg::*;
(
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    output logic [ALU_W-1:0] diff,
    output logic             ge
);

    logic [ALU_W:0] wide_diff;

    assign wide_diff = {1'b0, a} - {1'b0, b};
    assign ge        = ~wide_diff[ALU_W];
    assign diff      = wide_diff[ALU_W-1:0];

endmodule

@@ rtl/core/rms_error_accumulator.sv @@
`timescale 1ns / 1ps

// Accumulates the squared difference of each model and reference sample pair
// and, on the pair marked last, delivers floor(sqrt(sum * 65536 / count)),
// capped to 24 bits, with the pair count and an overflow flag, then clears
// its running state. A pair that is not last occupies the block while it
// takes the transfer and then squares the difference and adds it to the
// 44-bit sum. A last pair occupies it longer: one shared 34-bit subtract and
// compare unit produces one quotient bit per cycle over the 60-bit dividend,
// then one root bit per cycle for the 30-bit root. The finished result sits
// in an output register, so new pairs are taken while it waits to be
// transferred. If a later last pair finishes while that result is still
// held, the block stays busy in its final cycle until that one is transferred.
module rms_error_accumulator
    import rmse_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_SAMPLES = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [15:0]            model_sample,
    input  logic [15:0]            reference_sample,
    input  logic                   last_sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [RMS_W-1:0]       rms_value,
    output logic [COUNT_OUT_W-1:0] sample_count,
    output logic                   overflow
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(MAX_SAMPLES);

    rmse_state_t state_reg, state_next;

    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   dropped_reg, dropped_next;
    logic [MAG_W-1:0]       mag_reg, mag_next;
    logic                   last_reg, last_next;
    logic [DIVIDEND_W-1:0]  work_reg, work_next;
    logic [ALU_W-1:0]       rem_reg, rem_next;
    logic [ROOT_W-1:0]      root_reg, root_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   out_valid_reg, out_valid_next;
    logic [RMS_W-1:0]       rms_reg, rms_next;
    logic [COUNT_OUT_W-1:0] count_out_reg, count_out_next;
    logic                   overflow_reg, overflow_next;

    logic signed [17:0] model_ext;
    logic signed [17:0] reference_ext;
    logic signed [17:0] sample_diff;
    logic [MAG_W-1:0]   sample_mag;
    logic [SQ_W-1:0]    square;
    logic [SUM_W:0]     sum_wide;
    logic               in_xfer;
    logic               out_free;
    logic               count_open;
    logic [ALU_W-1:0]   alu_a;
    logic [ALU_W-1:0]   alu_b;
    logic [ALU_W-1:0]   alu_diff;
    logic               alu_ge;

    if (SAMPLE_BITS <= 16) begin : g_narrow
        assign model_ext     = 18'($signed(model_sample[SAMPLE_BITS-1:0]));
        assign reference_ext = 18'($signed(reference_sample[SAMPLE_BITS-1:0]));
    end
    else begin : g_wide
        assign model_ext     = $signed({2'b00, model_sample});
        assign reference_ext = $signed({2'b00, reference_sample});
    end

    assign sample_diff = model_ext - reference_ext;
    assign sample_mag  = sample_diff[17] ? MAG_W'(-sample_diff) : MAG_W'(sample_diff);
    assign square      = mag_reg * mag_reg;
    assign sum_wide    = {1'b0, sum_reg} + (SUM_W + 1)'(square);
    assign count_open  = count_reg < COUNT_LIMIT;

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    rmse_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .ge   (alu_ge)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                state_next = last_reg ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE:
            begin
                if (step_reg == DIV_LAST_STEP)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (step_reg == ROOT_LAST_STEP)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        alu_a    = '0;
        alu_b    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_DIVIDE:
            begin
                alu_a = ALU_W'({rem_reg[CNT_W-1:0], work_reg[DIVIDEND_W-1]});
                alu_b = ALU_W'(count_reg);
            end
            ST_ROOT:
            begin
                alu_a = {rem_reg[ALU_W-3:0], work_reg[DIVIDEND_W-1 -: 2]};
                alu_b = ALU_W'({root_reg, 2'b01});
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        sum_next       = sum_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        mag_next       = mag_reg;
        last_next      = last_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        rms_next       = rms_reg;
        count_out_next = count_out_reg;
        overflow_next  = overflow_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    mag_next  = sample_mag;
                    last_next = last_sample;
                end
            end
            ST_ACCUM:
            begin
                if (count_open)
                begin
                    sum_next   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                    count_next = count_reg + 1'b1;
                    work_next  = {sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0], 16'h0000};
                end
                else
                begin
                    dropped_next = 1'b1;
                    work_next    = {sum_reg, 16'h0000};
                end
                rem_next  = '0;
                root_next = '0;
                step_next = '0;
            end
            ST_DIVIDE:
            begin
                if (alu_ge)
                begin
                    rem_next = alu_diff;
                end
                else
                begin
                    rem_next = alu_a;
                end
                work_next = {work_reg[DIVIDEND_W-2:0], alu_ge};
                if (step_reg == DIV_LAST_STEP)
                begin
                    step_next = '0;
                    rem_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_ROOT:
            begin
                if (alu_ge)
                begin
                    rem_next = alu_diff;
                end
                else
                begin
                    rem_next = alu_a;
                end
                root_next = {root_reg[ROOT_W-2:0], alu_ge};
                work_next = {work_reg[DIVIDEND_W-3:0], 2'b00};
                step_next = step_reg + 1'b1;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (count_reg == '0)
                    begin
                        rms_next = '0;
                    end
                    else if (root_reg > ROOT_W'(RMS_MAX))
                    begin
                        rms_next = RMS_MAX;
                    end
                    else
                    begin
                        rms_next = root_reg[RMS_W-1:0];
                    end
                    count_out_next = COUNT_OUT_W'(count_reg);
                    overflow_next  = dropped_reg;
                    sum_next       = '0;
                    count_next     = '0;
                    dropped_next   = 1'b0;
                end
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        last_reg      <= last_next;
        work_reg      <= work_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        rms_reg       <= rms_next;
        count_out_reg <= count_out_next;
        overflow_reg  <= overflow_next;
    end

    assign out_valid    = out_valid_reg;
    assign rms_value    = rms_reg;
    assign sample_count = count_out_reg;
    assign overflow     = overflow_reg;

endmodule

@@ rtl/core/rmse_checker.sv @@
`timescale 1ns / 1ps

module rmse_assertions
    import rmse_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [RMS_W-1:0]       rms_value,
    input logic [COUNT_OUT_W-1:0] sample_count,
    input logic                   overflow
);

    // Every accepted pair keeps the block busy for at least the next cycle.
    a_busy_after_transfer: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall
    ) else $error("input taken again right after a transfer");

    // A new result only appears while the sequencer is busy.
    a_result_from_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall)
    ) else $error("result appeared while the block was idle");

    // A result is never replaced while the previous one is still held.
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(sample_count) && $stable(overflow)
    ) else $error("held result was overwritten");

    a_valid_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(rms_value)
    ) else $error("stalled result was dropped or changed");

endmodule

bind rms_error_accumulator rmse_assertions u_rmse_assertions (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rms_value    (rms_value),
    .sample_count (sample_count),
    .overflow     (overflow)
);
